// ===== hdl/fpcvt_pkg.sv =====
// Shared types and constants for the binary32/binary16 converter.
package fpcvt_pkg;

  typedef enum logic {
    FUNC_NARROW = 1'b0,
    FUNC_WIDEN  = 1'b1
  } func_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;

  localparam logic [7:0]  F32_EXP_MAX   = 8'hff;
  localparam logic [7:0]  F32_EXP_OVF   = 8'd143;
  localparam logic [7:0]  F32_EXP_SUB   = 8'd112;
  localparam logic [7:0]  F32_EXP_TINY  = 8'd102;
  localparam logic [7:0]  F32_SUB_SHIFT = 8'd126;
  localparam logic [7:0]  F32_EXP_MIN16 = 8'd113;
  localparam logic [7:0]  REBIAS        = 8'd112;

  localparam logic [4:0]  F16_EXP_MAX   = 5'h1f;
  localparam logic [14:0] F16_INF       = 15'h7c00;
  localparam logic [14:0] F16_QNAN      = 15'h7e00;

  typedef struct packed {
    logic        valid;
    logic        fixed;
    logic [31:0] fixed_val;
    logic        func;
    logic        sign;
    logic        sub;
    logic [4:0]  shamt;
    logic [23:0] mant;
    logic [4:0]  exp;
  } st1_t;

  typedef struct packed {
    logic        valid;
    logic        fixed;
    logic [31:0] fixed_val;
    logic        sign;
    logic [14:0] base;
    logic        rnd;
  } st2_t;

endpackage

// ===== hdl/fp16_fp32_convert_core.sv =====
// Three-stage pipelined converter between binary32 and binary16 bit patterns.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------------------
//  input   | in_func, in_operand            | start high while busy low
//  result  | out_converted                  | out_valid, one cycle, no backpressure
//
// One word enters per cycle. Its result is registered in s1_r, s2_r and res_r in
// turn and is then shown on the result ports with out_valid.
// Stage 1 classifies and counts leading zeros, stage 2 runs the alignment
// shifter, stage 3 adds the rounding increment and registers the result.
// busy stays low: the result side never stalls, so the pipeline never holds.
// Synchronous active-low reset clears every pipeline register.
module fp16_fp32_convert_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [fpcvt_pkg::WORD_W-1:0]   in_operand,
  output logic                           out_valid,
  output logic [fpcvt_pkg::WORD_W-1:0]   out_converted
);
  import fpcvt_pkg::*;

  st1_t        s1_r, s1_nxt;
  st2_t        s2_r, s2_nxt;
  logic        v3_r;
  logic [31:0] res_r, res_nxt;

  logic        accept;
  logic        n_sign;
  logic [7:0]  n_exp;
  logic [22:0] n_man;
  logic        w_sign;
  logic [4:0]  w_exp;
  logic [9:0]  w_man;
  logic [3:0]  w_pos;
  logic [7:0]  w_exp32;
  logic [7:0]  sub_sh;

  logic [24:0] n_shifted;
  logic [10:0] w_norm;
  logic [7:0]  w_exp_norm;
  logic [14:0] sum;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign n_sign  = in_operand[31];
  assign n_exp   = in_operand[30:23];
  assign n_man   = in_operand[22:0];
  assign w_sign  = in_operand[15];
  assign w_exp   = in_operand[14:10];
  assign w_man   = in_operand[9:0];
  assign w_exp32 = {3'b000, w_exp} + REBIAS;
  assign sub_sh  = F32_SUB_SHIFT - n_exp;

  always_comb begin
    w_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (w_man[i]) begin
        w_pos = 4'(i);
      end
    end
  end

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.valid     = accept;
    s1_nxt.func      = in_func;
    if (func_t'(in_func) == FUNC_NARROW) begin
      s1_nxt.sign  = n_sign;
      s1_nxt.mant  = {1'b1, n_man};
      s1_nxt.exp   = 5'(n_exp - REBIAS);
      s1_nxt.shamt = sub_sh[4:0];
      s1_nxt.sub   = (n_exp <= F32_EXP_SUB);
      if (n_exp == F32_EXP_MAX) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {16'h0000, n_sign, (n_man != '0) ? F16_QNAN : F16_INF};
      end else if (n_exp >= F32_EXP_OVF) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {16'h0000, n_sign, F16_INF};
      end else if (n_exp < F32_EXP_TINY) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {16'h0000, n_sign, 15'h0000};
      end
    end else begin
      s1_nxt.sign  = w_sign;
      s1_nxt.mant  = {14'h0000, w_man};
      s1_nxt.shamt = 5'(4'd10 - w_pos);
      s1_nxt.fixed = 1'b1;
      if (w_exp == '0) begin
        s1_nxt.fixed_val = {w_sign, 31'h0};
        if (w_man != '0) begin
          s1_nxt.fixed = 1'b0;
        end
      end else if (w_exp == F16_EXP_MAX) begin
        s1_nxt.fixed_val = {w_sign, F32_EXP_MAX, w_man, 13'h0000};
      end else begin
        s1_nxt.fixed_val = {w_sign, w_exp32, w_man, 13'h0000};
      end
    end
  end

  assign n_shifted  = {s1_r.mant, 1'b0} >> s1_r.shamt;
  assign w_norm     = {1'b0, s1_r.mant[9:0]} << s1_r.shamt[3:0];
  assign w_exp_norm = F32_EXP_MIN16 - {3'b000, s1_r.shamt};

  always_comb begin
    s2_nxt           = '0;
    s2_nxt.valid     = s1_r.valid;
    s2_nxt.sign      = s1_r.sign;
    s2_nxt.fixed     = s1_r.fixed;
    s2_nxt.fixed_val = s1_r.fixed_val;
    if (!s1_r.fixed) begin
      if (func_t'(s1_r.func) == FUNC_WIDEN) begin
        s2_nxt.fixed     = 1'b1;
        s2_nxt.fixed_val = {s1_r.sign, w_exp_norm, w_norm[9:0], 13'h0000};
      end else if (s1_r.sub) begin
        s2_nxt.base = n_shifted[15:1];
        s2_nxt.rnd  = n_shifted[0];
      end else begin
        s2_nxt.base = {s1_r.exp, s1_r.mant[22:13]};
        s2_nxt.rnd  = s1_r.mant[12];
      end
    end
  end

  assign sum     = s2_r.base + {14'h0000, s2_r.rnd};
  assign res_nxt = s2_r.fixed ? s2_r.fixed_val : {16'h0000, s2_r.sign, sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= '0;
      s2_r  <= '0;
      v3_r  <= 1'b0;
      res_r <= '0;
    end else begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      v3_r  <= s2_r.valid;
      res_r <= res_nxt;
    end
  end

  assign out_valid     = v3_r;
  assign out_converted = res_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the binary32/binary16 converter core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpcvt_pkg::*;

  typedef struct {
    func_t       func;
    logic [31:0] operand;
    logic [31:0] converted;
  } conversion_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [31:0] in_operand;
  logic        out_valid;
  logic [31:0] out_converted;

  conversion_t pending_conversions[$];
  int unsigned error_count;
  int unsigned burst_left;

  fp16_fp32_convert_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_converted (out_converted)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [15:0] narrow_to_half(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  efield;
    logic [23:0] mant;
    logic [15:0] half;
    int unsigned shift;
    sign   = bits[31];
    efield = bits[30:23];
    mant   = {1'b0, bits[22:0]};
    if (efield == 8'hff) begin
      if (mant != 24'd0) return {sign, 15'h7e00};
      return {sign, 15'h7c00};
    end
    if (efield >= 8'd143) return {sign, 15'h7c00};
    if (efield <= 8'd112) begin
      if (efield < 8'd102) return {sign, 15'd0};
      mant[23] = 1'b1;
      shift = 126 - efield;
      half = 16'(mant >> shift);
      if (mant[shift-1]) half = half + 16'd1;
      return {sign, 15'd0} | half;
    end
    half = {sign, 5'(efield - 8'd112), mant[22:13]};
    if (mant[12]) half = half + 16'd1;
    return half;
  endfunction

  function automatic logic [31:0] widen_to_single(input logic [15:0] value);
    logic        sign;
    logic [4:0]  efield;
    logic [10:0] mant;
    logic [7:0]  exp32;
    sign   = value[15];
    efield = value[14:10];
    mant   = {1'b0, value[9:0]};
    if (efield == 5'd0) begin
      if (mant == 11'd0) return {sign, 31'd0};
      exp32 = 8'd113;
      while (!mant[10]) begin
        mant  = mant << 1;
        exp32 = exp32 - 8'd1;
      end
      return {sign, exp32, mant[9:0], 13'd0};
    end
    if (efield == 5'h1f) return {sign, 8'hff, mant[9:0], 13'd0};
    return {sign, 8'(efield) + 8'd112, mant[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] convert_word(input func_t func, input logic [31:0] operand);
    if (func == FUNC_NARROW) return {16'd0, narrow_to_half(operand)};
    return widen_to_single(operand[15:0]);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic send_word(input func_t func, input logic [31:0] operand);
    conversion_t rec;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
    @(negedge clk);
    start      = 1'b1;
    in_func    = func;
    in_operand = operand;
    do @(posedge clk); while (busy);
    rec.func      = func;
    rec.operand   = operand;
    rec.converted = convert_word(func, operand);
    pending_conversions.push_back(rec);
    burst_left--;
  endtask

  always @(posedge clk) begin
    conversion_t rec;
    if (rst_n && out_valid) begin
      if (pending_conversions.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_converted));
      end else begin
        rec = pending_conversions.pop_front();
        if (out_converted !== rec.converted)
          report_mismatch($sformatf("%s %h: got %h, want %h", rec.func.name(), rec.operand,
                                    out_converted, rec.converted));
      end
    end
  end

  task automatic test_narrow_specials();
    send_word(FUNC_NARROW, 32'h0000_0000);
    send_word(FUNC_NARROW, 32'h8000_0000);
    send_word(FUNC_NARROW, 32'h7f80_0000);
    send_word(FUNC_NARROW, 32'hff80_0000);
    send_word(FUNC_NARROW, 32'h7fc0_0000);
    send_word(FUNC_NARROW, 32'hff80_0001);
    send_word(FUNC_NARROW, 32'hffff_ffff);
    send_word(FUNC_NARROW, 32'h7f7f_ffff);
    send_word(FUNC_NARROW, 32'h477f_ffff);
    send_word(FUNC_NARROW, 32'h4780_0000);
    send_word(FUNC_NARROW, 32'h807f_ffff);
    send_word(FUNC_NARROW, 32'h32ff_ffff);
    send_word(FUNC_NARROW, 32'h3300_0000);
    send_word(FUNC_NARROW, 32'h387f_ffff);
    send_word(FUNC_NARROW, 32'hbf80_1000);
    send_word(FUNC_NARROW, 32'h3f80_0fff);
  endtask

  task automatic test_widen_specials();
    send_word(FUNC_WIDEN, 32'h0000_0000);
    send_word(FUNC_WIDEN, 32'h0000_8000);
    send_word(FUNC_WIDEN, 32'h0000_0001);
    send_word(FUNC_WIDEN, 32'h0000_83ff);
    send_word(FUNC_WIDEN, 32'h0000_0400);
    send_word(FUNC_WIDEN, 32'h0000_7bff);
    send_word(FUNC_WIDEN, 32'h0000_fc00);
    send_word(FUNC_WIDEN, 32'h0000_7c01);
    send_word(FUNC_WIDEN, 32'hffff_7e00);
    send_word(FUNC_WIDEN, 32'hdead_3c00);
  endtask

  task automatic test_random_words(input int unsigned count);
    logic [31:0] operand;
    logic [7:0]  exp8;
    logic [4:0]  exp5;
    int unsigned kind;
    repeat (count) begin
      operand = $urandom();
      kind    = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          send_word(FUNC_NARROW, operand);
        end
        3, 4, 5: begin
          exp8 = 8'($urandom_range(98, 146));
          if ($urandom_range(0, 3) == 0) operand[12:0] = {1'b1, 12'd0};
          send_word(FUNC_NARROW, {operand[31], exp8, operand[22:0]});
        end
        6: begin
          exp8 = $urandom_range(0, 1) ? 8'hff : 8'h00;
          if ($urandom_range(0, 2) == 0) operand[22:0] = 23'd0;
          send_word(FUNC_NARROW, {operand[31], exp8, operand[22:0]});
        end
        7, 8: begin
          send_word(FUNC_WIDEN, operand);
        end
        default: begin
          exp5 = $urandom_range(0, 1) ? 5'h1f : 5'h00;
          if ($urandom_range(0, 2) == 0) operand[9:0] = 10'd0;
          send_word(FUNC_WIDEN, {operand[31:15], exp5, operand[9:0]});
        end
      endcase
    end
  endtask

  initial begin
    int unsigned drain;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = 1'b0;
    in_operand  = 32'd0;
    error_count = 0;
    burst_left  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_narrow_specials();
    test_widen_specials();
    test_random_words(1200);

    @(negedge clk);
    start = 1'b0;
    drain = 0;
    while (pending_conversions.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_conversions.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_conversions.size()));
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #1ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
